// ----- hdl/plpoc_pkg.sv -----
// plpoc_pkg: shared types and constants for the per-line pattern occurrence counter.
// No dependencies. Used by plpoc_match and per_line_pattern_occurrence_counter_top.
package plpoc_pkg;

  localparam int MAX_PATTERN_BYTES_DEF = 32;

  localparam int LEN_W      = 6;
  localparam int PAT_WORDS  = 4;
  localparam int PAT_BYTES  = 32;
  localparam int PAT_IDX_W  = $clog2(PAT_BYTES);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LINE_W     = 32;
  localparam int COUNT_W    = 16;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  typedef logic [7:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 3'd0,
    CFG_PATTERN_LO     = 3'd1,
    CFG_PATTERN_MID_LO = 3'd2,
    CFG_PATTERN_MID_HI = 3'd3,
    CFG_PATTERN_HI     = 3'd4
  } cfg_reg_t;

endpackage

// ----- hdl/plpoc_match.sv -----
// plpoc_match: parallel window-against-pattern compare for one text byte.
// Depends on plpoc_pkg.
module plpoc_match import plpoc_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
  localparam int CNT_W = $clog2(MAX_PATTERN_BYTES + 1)
) (
  input  byte_t [MAX_PATTERN_BYTES-1:0] window,   // entry 0 is the newest byte
  input  byte_t [PAT_BYTES-1:0]         pattern,
  input  logic  [LEN_W-1:0]             eff_len,
  input  logic  [CNT_W-1:0]             fill,
  output logic                          hit
);

  logic [MAX_PATTERN_BYTES-1:0] byte_ok;

  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cmp
    logic [LEN_W-1:0] pidx;
    assign pidx       = eff_len - LEN_W'(i + 1);
    assign byte_ok[i] = (LEN_W'(i) >= eff_len) || (window[i] == pattern[pidx[PAT_IDX_W-1:0]]);
  end

  assign hit = (&byte_ok) && (LEN_W'(fill) >= eff_len);

endmodule

// ----- hdl/per_line_pattern_occurrence_counter_top.sv -----
// per_line_pattern_occurrence_counter_top: stream front end, line state and result register.
// Depends on plpoc_pkg and plpoc_match.
//
// Takes one text byte per cycle, unless a pending result stalls the input, and counts overlapping
// occurrences of a 1 to 32 byte pattern on each line; a newline or an end-of-text transaction
// closes the line and, if the count is nonzero, yields one result with the 1-based line number
// and the count (both saturating). A byte is registered on entry and then processed, when the
// result register is free, by a combinational parallel compare of the whole window. The pattern
// is taken from the configuration registers, which the user must write only while no
// transaction is in flight; the block itself does not enforce this.
module per_line_pattern_occurrence_counter_top import plpoc_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] text_byte
  input  logic                  in_tuser,   // [0] end_of_text
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // [31:0] line_number, [47:32] match_count
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_PATTERN_BYTES + 1);

  // configuration
  logic [LEN_W-1:0]                        pat_len_r;
  logic [PAT_WORDS-1:0][CFG_DATA_W-1:0]    pat_words_r;
  byte_t [PAT_BYTES-1:0]                   pat_bytes;
  logic [LEN_W-1:0]                        eff_len;

  // input stage
  logic  s1_valid_r, s1_valid_nxt;
  byte_t s1_byte_r;
  logic  s1_eot_r;

  // line state
  byte_t [MAX_PATTERN_BYTES-1:0] window_r, window_nxt;
  logic [CNT_W-1:0]              fill_r, fill_nxt;
  logic [COUNT_W-1:0]            matches_r, matches_nxt;
  logic [LINE_W-1:0]             line_r, line_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [LINE_W-1:0]  out_line_r;
  logic [COUNT_W-1:0] out_count_r;

  logic out_free, s1_adv, line_close, hit, emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r   <= LEN_W'(1);
      pat_words_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PATTERN_LENGTH: pat_len_r      <= cfg_wdata[LEN_W-1:0];
        CFG_PATTERN_LO:     pat_words_r[0] <= cfg_wdata;
        CFG_PATTERN_MID_LO: pat_words_r[1] <= cfg_wdata;
        CFG_PATTERN_MID_HI: pat_words_r[2] <= cfg_wdata;
        CFG_PATTERN_HI:     pat_words_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign pat_bytes = pat_words_r;

  always_comb begin
    if (pat_len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (pat_len_r > LEN_W'(MAX_PATTERN_BYTES)) begin
      eff_len = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      eff_len = pat_len_r;
    end
  end

  // handshake
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_eot_r  <= in_tuser;
    end
  end

  // byte processing
  always_comb begin
    window_nxt[0] = s1_byte_r;
    for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
      window_nxt[i] = window_r[i-1];
    end
    fill_nxt = (fill_r == CNT_W'(MAX_PATTERN_BYTES)) ? fill_r : fill_r + CNT_W'(1);
  end

  plpoc_match #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_match (
    .window  (window_nxt),
    .pattern (pat_bytes),
    .eff_len (eff_len),
    .fill    (fill_nxt),
    .hit     (hit)
  );

  assign line_close = s1_eot_r || (s1_byte_r == NEWLINE_BYTE);
  assign emit       = s1_adv && line_close && (matches_r != '0);

  always_comb begin
    matches_nxt = matches_r;
    line_nxt    = line_r;
    if (line_close) begin
      matches_nxt = '0;
      if (line_r != '1) begin
        line_nxt = line_r + LINE_W'(1);
      end
    end else if (hit && (matches_r != '1)) begin
      matches_nxt = matches_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      matches_r <= '0;
      line_r    <= LINE_W'(1);
    end else if (s1_adv) begin
      fill_r    <= line_close ? '0 : fill_nxt;
      matches_r <= matches_nxt;
      line_r    <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && !line_close) begin
      window_r <= window_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_line_r  <= line_r;
      out_count_r <= matches_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_line_r};

endmodule
